/* rtl/lpc_pkg.sv */
package lpc_pkg;

    // Field widths of one input word and one result word.
    localparam int PAGE_ID_W   = 32;
    localparam int PAGE_REF_W  = 32;
    localparam int VALUE_W     = 32;
    localparam int S_TDATA_W   = PAGE_ID_W + PAGE_REF_W;
    localparam int M_TDATA_W   = VALUE_W + PAGE_ID_W;
    localparam int M_TUSER_W   = 2;

    // Capacity register.
    localparam int          CAP_W     = 5;
    localparam logic [4:0]  CAP_RESET = 5'd16;

    // Default number of entries.
    localparam int ENTRIES_DEFAULT = 16;

    // Operation codes carried on s_tuser.
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_STORE  = 1'b1;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_COMMIT
    } lpc_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic match;
        logic commit;
    } lpc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } lpc_status_t;

endpackage

/* rtl/lpc_ram.sv */
module lpc_ram
    import lpc_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/lpc_ctrl.sv */
module lpc_ctrl
    import lpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  lpc_status_t status,
    output lpc_cmd_t    cmd
);

    lpc_state_t state_reg;
    lpc_state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state: a word is matched for one cycle, then committed once the
    // output register can take its result.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH: begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (status.out_free) begin
                    state_next = s_tvalid ? ST_MATCH : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs: the next word is taken in the same cycle as the commit.
    always_comb begin
        s_tready   = 1'b0;
        cmd.match  = 1'b0;
        cmd.commit = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_MATCH: begin
                cmd.match = 1'b1;
            end
            ST_COMMIT: begin
                s_tready   = status.out_free;
                cmd.commit = status.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
        cmd.load = s_tvalid && s_tready;
    end

endmodule

/* rtl/lpc_datapath.sv */
module lpc_datapath
    import lpc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lpc_cmd_t             cmd,
    output lpc_status_t          status,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser,
    input  logic                 cfg_we,
    input  logic [CAP_W-1:0]     cfg_wdata
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int RANK_W = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // Capacity register.
    logic [CAP_W-1:0] cap_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_we) begin
            cap_reg <= cfg_wdata;
        end
    end

    // Item registers, loaded when a word is accepted.
    logic                  item_cmd_reg;
    logic [PAGE_ID_W-1:0]  item_key_reg;
    logic [PAGE_REF_W-1:0] item_ref_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_cmd_reg <= s_tuser;
            item_key_reg <= s_tdata[PAGE_ID_W-1:0];
            item_ref_reg <= s_tdata[S_TDATA_W-1:PAGE_ID_W];
        end
    end

    // Entry state: keys, ranks and valid bits in flops, values in RAM.
    logic [PAGE_ID_W-1:0] key_reg   [ENTRIES];
    logic [RANK_W-1:0]    rank_reg  [ENTRIES];
    logic [RANK_W-1:0]    rank_next [ENTRIES];
    logic [ENTRIES-1:0]   valid_reg;
    logic [ENTRIES-1:0]   valid_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    // Clamp the capacity to 1 .. ENTRIES and compare with the fill count.
    logic [CMP_W-1:0] eff_cap;
    logic             full;

    always_comb begin
        if (cap_reg == '0) begin
            eff_cap = CMP_W'(1);
        end else if (CMP_W'(cap_reg) > CMP_W'(ENTRIES)) begin
            eff_cap = CMP_W'(ENTRIES);
        end else begin
            eff_cap = CMP_W'(cap_reg);
        end
        full = CMP_W'(count_reg) >= eff_cap;
    end

    // Associative match. The least recent entry is the valid one whose rank
    // equals the count minus one, since valid ranks are always 0 .. count-1.
    logic [RANK_W-1:0]  last_rank;
    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES-1:0] oldest_vec;
    logic [ENTRIES-1:0] free_vec;
    logic               hit_c;
    logic               evict_c;
    logic [IDX_W-1:0]   hit_idx_c;
    logic [IDX_W-1:0]   victim_idx_c;
    logic [IDX_W-1:0]   ins_idx_c;

    assign last_rank = RANK_W'(count_reg - CNT_W'(1));

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match_vec[i]  = valid_reg[i] && (key_reg[i] == item_key_reg);
            oldest_vec[i] = valid_reg[i] && (rank_reg[i] == last_rank);
        end
        hit_c   = |match_vec;
        evict_c = (item_cmd_reg == CMD_STORE) && !hit_c && full;
        for (int i = 0; i < ENTRIES; i++) begin
            free_vec[i] = !valid_reg[i] || (evict_c && oldest_vec[i]);
        end
    end

    // Priority encoders: each picks the lowest set index.
    always_comb begin
        hit_idx_c    = '0;
        victim_idx_c = '0;
        ins_idx_c    = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match_vec[i]) begin
                hit_idx_c = IDX_W'(i);
            end
            if (oldest_vec[i]) begin
                victim_idx_c = IDX_W'(i);
            end
            if (free_vec[i]) begin
                ins_idx_c = IDX_W'(i);
            end
        end
    end

    // Match results, held for the commit cycle.
    logic             hit_reg;
    logic             evict_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [IDX_W-1:0] victim_idx_reg;
    logic [IDX_W-1:0] ins_idx_reg;

    always_ff @(posedge aclk) begin
        if (cmd.match) begin
            hit_reg        <= hit_c;
            evict_reg      <= evict_c;
            hit_idx_reg    <= hit_idx_c;
            victim_idx_reg <= victim_idx_c;
            ins_idx_reg    <= ins_idx_c;
        end
    end

    // Value store: read at the hit entry during match, written on commit.
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [VALUE_W-1:0]   ram_rdata;
    logic                 store_miss;
    logic [RANK_W-1:0]    hit_rank;

    assign store_miss = (item_cmd_reg == CMD_STORE) && !hit_reg;
    assign ram_we     = cmd.commit && (item_cmd_reg == CMD_STORE);
    assign ram_waddr  = hit_reg ? hit_idx_reg : ins_idx_reg;
    assign hit_rank   = rank_reg[hit_idx_reg];

    lpc_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (ENTRIES)
    ) u_value_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (item_ref_reg),
        .re    (cmd.match),
        .raddr (hit_idx_c),
        .rdata (ram_rdata)
    );

    // Recency, valid and count update for the commit cycle.
    always_comb begin
        valid_next = valid_reg;
        count_next = count_reg;
        for (int i = 0; i < ENTRIES; i++) begin
            rank_next[i] = rank_reg[i];
        end
        if (cmd.commit && hit_reg) begin
            // A hit ages every entry that was more recent than the hit one.
            for (int i = 0; i < ENTRIES; i++) begin
                if (IDX_W'(i) == hit_idx_reg) begin
                    rank_next[i] = '0;
                end else if (valid_reg[i] && (rank_reg[i] < hit_rank)) begin
                    rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
            end
        end else if (cmd.commit && store_miss) begin
            // An insert ages every surviving entry and drops the victim.
            if (evict_reg) begin
                valid_next[victim_idx_reg] = 1'b0;
            end else begin
                count_next = count_reg + CNT_W'(1);
            end
            for (int i = 0; i < ENTRIES; i++) begin
                if (IDX_W'(i) == ins_idx_reg) begin
                    rank_next[i] = '0;
                end else if (evict_reg && (IDX_W'(i) == victim_idx_reg)) begin
                    rank_next[i] = '0;
                end else if (valid_reg[i]) begin
                    rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
            end
            valid_next[ins_idx_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    // Key write on insert.
    always_ff @(posedge aclk) begin
        if (cmd.commit && store_miss) begin
            key_reg[ins_idx_reg] <= item_key_reg;
        end
    end

    // Output register.
    logic                 m_tvalid_reg;
    logic                 m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;
    logic [VALUE_W-1:0]   value_c;
    logic [PAGE_ID_W-1:0] evicted_id_c;

    assign status.out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        value_c      = (hit_reg && (item_cmd_reg == CMD_LOOKUP)) ? ram_rdata : '0;
        evicted_id_c = evict_reg ? key_reg[victim_idx_reg] : '0;
        if (cmd.commit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_tdata_reg <= {evicted_id_c, value_c};
            m_tuser_reg <= {evict_reg, hit_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* rtl/lru_page_cache_core.sv */
// Each accepted word takes a match cycle over all entry keys, then a commit
// cycle that updates ranks, keys and the value RAM port and loads the output
// register once it is free; the next word can be taken in that commit cycle.
// Reset clears all valid bits and the fill count at once and sets capacity to
// 16; key and value storage is not cleared.
module lru_page_cache_core
    import lpc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // page_id [31:0], page_ref [63:32]
    input  logic                 s_tuser,   // cmd [0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // value [31:0], evicted_page_id [63:32]
    output logic [M_TUSER_W-1:0] m_tuser,   // hit [0], evicted [1]
    input  logic                 cfg_we,
    input  logic [CAP_W-1:0]     cfg_wdata  // capacity [4:0]
);

    lpc_cmd_t    cmd;
    lpc_status_t status;

    // Sequencer.
    lpc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Entry storage, match logic and output register.
    lpc_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

endmodule

/* dv/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lpc_pkg::*;

    localparam int ENTRIES     = ENTRIES_DEFAULT;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_WORDS = 60;
    localparam int KEY_POOL    = 24;
    localparam int PRINT_LIMIT = 40;

    // One result word, split into its fields.
    typedef struct packed {
        logic        hit;
        logic [31:0] value;
        logic        evicted;
        logic [31:0] evicted_id;
    } cache_result_t;

    // A row of the directed table is either a word to send or a capacity write.
    typedef enum logic [1:0] {
        ROW_WORD,
        ROW_CAP
    } row_kind_t;

    typedef struct packed {
        row_kind_t     kind;
        logic          cmd;
        logic [31:0]   page_id;
        logic [31:0]   page_ref;
        logic [4:0]    cap;
        logic          typed;
        cache_result_t want;
    } plan_row_t;

    localparam int PLAN_LEN = 23;

    // Rows with typed set carry their expected result; the others use the predictor.
    plan_row_t plan [PLAN_LEN] = '{
        '{ROW_WORD, CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b1,
          '{1'b0, 32'h0000_0000, 1'b0, 32'h0000_0000}},
        '{ROW_WORD, CMD_STORE,  32'h8000_0000, 32'hFFFF_FFFF, 5'd0, 1'b1,
          '{1'b0, 32'h0000_0000, 1'b0, 32'h0000_0000}},
        '{ROW_WORD, CMD_LOOKUP, 32'h8000_0000, 32'h0000_0000, 5'd0, 1'b1,
          '{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000}},
        '{ROW_WORD, CMD_STORE,  32'h7FFF_FFFF, 32'h0000_0000, 5'd0, 1'b1,
          '{1'b0, 32'h0000_0000, 1'b0, 32'h0000_0000}},
        '{ROW_WORD, CMD_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000, 5'd0, 1'b1,
          '{1'b1, 32'h0000_0000, 1'b0, 32'h0000_0000}},
        '{ROW_WORD, CMD_STORE,  32'h7FFF_FFFF, 32'h1234_5678, 5'd0, 1'b1,
          '{1'b1, 32'h0000_0000, 1'b0, 32'h0000_0000}},
        '{ROW_WORD, CMD_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000, 5'd0, 1'b1,
          '{1'b1, 32'h1234_5678, 1'b0, 32'h0000_0000}},
        '{ROW_WORD, CMD_STORE,  32'hFFFF_FFFF, 32'hA5A5_A5A5, 5'd0, 1'b1,
          '{1'b0, 32'h0000_0000, 1'b0, 32'h0000_0000}},
        '{ROW_WORD, CMD_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 5'd0, 1'b1,
          '{1'b0, 32'h0000_0000, 1'b0, 32'h0000_0000}},
        '{ROW_WORD, CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 5'd0, 1'b1,
          '{1'b1, 32'hA5A5_A5A5, 1'b0, 32'h0000_0000}},
        // Capacity dropped below the fill count: each insert evicts one.
        '{ROW_CAP,  CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 5'd2, 1'b0, '0},
        '{ROW_WORD, CMD_STORE,  32'h0000_0001, 32'h0000_0001, 5'd0, 1'b1,
          '{1'b0, 32'h0000_0000, 1'b1, 32'h8000_0000}},
        '{ROW_WORD, CMD_STORE,  32'h0000_0002, 32'h0000_0002, 5'd0, 1'b1,
          '{1'b0, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF}},
        '{ROW_WORD, CMD_LOOKUP, 32'h8000_0000, 32'h0000_0000, 5'd0, 1'b1,
          '{1'b0, 32'h0000_0000, 1'b0, 32'h0000_0000}},
        // A capacity of zero behaves as one.
        '{ROW_CAP,  CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b0, '0},
        '{ROW_WORD, CMD_STORE,  32'h0000_0003, 32'hFFFF_FFFF, 5'd0, 1'b1,
          '{1'b0, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF}},
        '{ROW_WORD, CMD_LOOKUP, 32'h0000_0002, 32'h0000_0000, 5'd0, 1'b1,
          '{1'b1, 32'h0000_0002, 1'b0, 32'h0000_0000}},
        // Updating a present key never evicts, even when the cache is over capacity.
        '{ROW_WORD, CMD_STORE,  32'h0000_0002, 32'h0000_0000, 5'd0, 1'b1,
          '{1'b1, 32'h0000_0000, 1'b0, 32'h0000_0000}},
        '{ROW_WORD, CMD_STORE,  32'h0000_0004, 32'hDEAD_BEEF, 5'd0, 1'b0, '0},
        // A capacity above the entry count behaves as the entry count.
        '{ROW_CAP,  CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 5'd31, 1'b0, '0},
        '{ROW_WORD, CMD_STORE,  32'h0000_0005, 32'h0000_0005, 5'd0, 1'b0, '0},
        '{ROW_WORD, CMD_LOOKUP, 32'h0000_0003, 32'h0000_0000, 5'd0, 1'b0, '0},
        '{ROW_CAP,  CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 5'd16, 1'b0, '0}
    };

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;    // page_id [31:0], page_ref [63:32]
    logic                 s_tuser;    // cmd [0]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;    // value [31:0], evicted_page_id [63:32]
    logic [M_TUSER_W-1:0] m_tuser;    // hit [0], evicted [1]
    logic                 cfg_we;
    logic [CAP_W-1:0]     cfg_wdata;

    // Shadow copy of the cache contents and the capacity register.
    logic [31:0]      shadow_key  [ENTRIES];
    logic [31:0]      shadow_data [ENTRIES];
    bit               shadow_live [ENTRIES];
    int unsigned      shadow_age  [ENTRIES];
    int unsigned      shadow_fill;
    logic [CAP_W-1:0] shadow_cap;

    cache_result_t pending_results [$];
    logic [31:0]   key_pool [KEY_POOL];
    int            mismatch_count = 0;
    int            result_count   = 0;
    bit            calm           = 1'b0;
    bit            hold_req       = 1'b0;

    lru_page_cache_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Random idle length: mostly none or short, now and then long.
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm) return 0;
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // Every live entry more recent than the given rank grows one step older.
    function automatic void age_entries(int unsigned limit);
        for (int i = 0; i < ENTRIES; i++) begin
            if (shadow_live[i] && shadow_age[i] < limit) shadow_age[i]++;
        end
    endfunction

    // Work out the result of one word and apply it to the shadow cache.
    function automatic cache_result_t predict_access(logic cmd, logic [31:0] id,
                                                     logic [31:0] data);
        cache_result_t r;
        int            slot;
        int            victim;
        int unsigned   oldest;
        int unsigned   limit;
        bit            placed;
        r = '0;
        slot = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && shadow_live[i] && shadow_key[i] == id) slot = i;
        end

        if (slot >= 0) begin
            r.hit = 1'b1;
            if (cmd == CMD_LOOKUP) r.value = shadow_data[slot];
            else shadow_data[slot] = data;
            age_entries(shadow_age[slot]);
            shadow_age[slot] = 0;
            return r;
        end
        if (cmd == CMD_LOOKUP) return r;

        limit = (shadow_cap == 0) ? 1 : ((shadow_cap > ENTRIES) ? ENTRIES : shadow_cap);
        if (shadow_fill >= limit) begin
            victim = -1;
            oldest = 0;
            for (int i = 0; i < ENTRIES; i++) begin
                if (shadow_live[i] && (victim < 0 || shadow_age[i] > oldest)) begin
                    victim = i;
                    oldest = shadow_age[i];
                end
            end
            if (victim >= 0) begin
                shadow_live[victim] = 1'b0;
                shadow_age[victim]  = 0;
                if (shadow_fill > 0) shadow_fill--;
                r.evicted    = 1'b1;
                r.evicted_id = shadow_key[victim];
            end
        end

        // Insert into the first free slot as the most recent entry.
        placed = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (!placed && !shadow_live[i]) begin
                age_entries(ENTRIES);
                shadow_live[i] = 1'b1;
                shadow_key[i]  = id;
                shadow_data[i] = data;
                shadow_age[i]  = 0;
                shadow_fill++;
                placed = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("MISMATCH %s at result %0d: got %h, expected %h",
                     what, result_count, got, want);
    endtask

    // Offer one word and record its expected result once it is accepted.
    task automatic send_word(logic cmd, logic [31:0] id, logic [31:0] data,
                             bit typed, cache_result_t want);
        int            gap;
        cache_result_t got;
        gap = idle_len();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom};
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {data, id};
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        got = predict_access(cmd, id, data);
        pending_results.push_back(typed ? want : got);
    endtask

    // Capacity is only changed once every result has come back.
    task automatic write_capacity(logic [CAP_W-1:0] cap);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (3) @(negedge aclk);
        cfg_wdata <= cap;
        cfg_we    <= 1'b1;
        @(negedge aclk);
        cfg_we     <= 1'b0;
        shadow_cap = cap;
    endtask

    // Random key: mostly from a small pool so that hits and evictions happen.
    function automatic logic [31:0] pick_key(int span);
        if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, span)];
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_ref();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 32'h0000_0000;
        if (roll == 1) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        int stall_left;
        int held;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                for (held = 1; held < HOLD_CYCLES; held++) @(negedge aclk);
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = idle_len();
            end
        end
    end

    // Compare each accepted result word with the oldest expectation.
    always @(posedge aclk) begin
        cache_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            result_count++;
            if (pending_results.size() == 0) begin
                report_mismatch("word with nothing expected", m_tdata[31:0], 32'h0);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser[0] !== want.hit)
                    report_mismatch("hit", {31'b0, m_tuser[0]}, {31'b0, want.hit});
                if (m_tdata[31:0] !== want.value)
                    report_mismatch("value", m_tdata[31:0], want.value);
                if (m_tuser[1] !== want.evicted)
                    report_mismatch("evicted", {31'b0, m_tuser[1]}, {31'b0, want.evicted});
                if (m_tdata[63:32] !== want.evicted_id)
                    report_mismatch("evicted_page_id", m_tdata[63:32], want.evicted_id);
            end
        end
    end

    // Watchdog on the whole run.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        logic [CAP_W-1:0] phase_cap [8];
        int               span;
        logic             cmd;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_LOOKUP;
        cfg_we    = 1'b0;
        cfg_wdata = '0;

        for (int i = 0; i < ENTRIES; i++) begin
            shadow_key[i]  = '0;
            shadow_data[i] = '0;
            shadow_live[i] = 1'b0;
            shadow_age[i]  = 0;
        end
        shadow_fill = 0;
        shadow_cap  = CAP_RESET;

        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < KEY_POOL; i++) key_pool[i] = $urandom;

        phase_cap = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd16, 5'd2, 5'd9};
        phase_cap[7] = $urandom_range(0, 31);

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table.
        for (int r = 0; r < PLAN_LEN; r++) begin
            if (plan[r].kind == ROW_CAP)
                write_capacity(plan[r].cap);
            else
                send_word(plan[r].cmd, plan[r].page_id, plan[r].page_ref,
                          plan[r].typed, plan[r].want);
        end

        // Random phases, each under its own capacity; two run without gaps,
        // and one of those carries the long result-side hold-off.
        for (int p = 0; p < 8; p++) begin
            write_capacity(phase_cap[p]);
            calm = (p == 3 || p == 5);
            span = (phase_cap[p] <= 4) ? 5 : KEY_POOL - 1;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (p == 5 && n == 10) hold_req = 1'b1;
                cmd = ($urandom_range(0, 99) < 45) ? CMD_LOOKUP : CMD_STORE;
                send_word(cmd, pick_key(span), pick_ref(), 1'b0, '0);
            end
        end
        calm = 1'b0;

        // Drain and let a few more cycles pass for stray words.
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
